// File: rtl/ini_line_tokenizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the line tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef INI_LINE_TOKENIZER_UNIT_MACROS_SVH
`define INI_LINE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ILT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ILT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg
// Types and codes shared by the configuration line tokenizer modules.
// ----------------------------------------------------------------------------
package ilt_pkg;

   // Character constants.
   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] CHAR_LBR = 8'h5B;
   localparam logic [7:0] CHAR_RBR = 8'h5D;
   localparam logic [7:0] CHAR_EQ  = 8'h3D;
   localparam logic [7:0] CHAR_UND = 8'h5F;
   localparam logic [7:0] CHAR_DSH = 8'h2D;

   // Byte roles.
   localparam logic [2:0] ROLE_IGNORED = 3'd0;
   localparam logic [2:0] ROLE_SECTION = 3'd1;
   localparam logic [2:0] ROLE_NAME    = 3'd2;
   localparam logic [2:0] ROLE_VALUE   = 3'd3;
   localparam logic [2:0] ROLE_DELIM   = 3'd4;

   // Token start codes.
   localparam logic [2:0] START_NONE  = 3'd0;
   localparam logic [2:0] START_SECT  = 3'd1;
   localparam logic [2:0] START_NAME  = 3'd2;
   localparam logic [2:0] START_VALUE = 3'd3;
   localparam logic [2:0] START_EMPTY = 3'd4;

   // Error codes.
   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_LINE_START = 4'd1;
   localparam logic [3:0] ERR_SECT_START = 4'd2;
   localparam logic [3:0] ERR_SECTION    = 4'd3;
   localparam logic [3:0] ERR_NAME_EOL   = 4'd4;
   localparam logic [3:0] ERR_NAME       = 4'd5;
   localparam logic [3:0] ERR_PRE_EQ_EOL = 4'd6;
   localparam logic [3:0] ERR_PRE_EQ     = 4'd7;
   localparam logic [3:0] ERR_POST_EQ    = 4'd8;
   localparam logic [3:0] ERR_VALUE      = 4'd9;
   localparam logic [3:0] ERR_END        = 4'd10;

   // Request word.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_of_line;
   } req_payload_type;

   // Response word.
   typedef struct packed {
      logic [2:0] byte_role;
      logic [2:0] token_start;
      logic [3:0] error_code;
      logic       line_done;
      logic       line_ok;
      logic       saw_section;
      logic       saw_name;
      logic       saw_value;
   } rsp_payload_type;

   // Classified byte, as it travels from front to back.
   typedef struct packed {
      logic is_nl;
      logic is_space;
      logic is_lbr;
      logic is_rbr;
      logic is_eq;
      logic is_ident;
      logic is_print;
      logic last;
   } ilt_class_type;

endpackage

// File: rtl/ilt_front.sv
// ----------------------------------------------------------------------------
// ilt_front
// Accepts request words and sorts each byte into its character classes.
// ----------------------------------------------------------------------------
module ilt_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ilt_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     push,
   output ilt_pkg::ilt_class_type   push_item
);
   import ilt_pkg::*;

   logic [7:0] c;

   assign c = req_payload.byte_in;

   // A word is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // ASCII class decode.
   always_comb begin
      push_item          = '0;
      push_item.is_nl    = (c == CHAR_NL);
      push_item.is_space = (c inside {[8'h09:8'h0D], 8'h20});
      push_item.is_lbr   = (c == CHAR_LBR);
      push_item.is_rbr   = (c == CHAR_RBR);
      push_item.is_eq    = (c == CHAR_EQ);
      push_item.is_ident = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
                           || (c == CHAR_UND) || (c == CHAR_DSH);
      push_item.is_print = (c inside {[8'h20:8'h7E]});
      push_item.last     = req_payload.last_of_line;
   end

endmodule

// File: rtl/ilt_queue.sv
// ----------------------------------------------------------------------------
// ilt_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module ilt_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ilt_pkg::ilt_class_type push_item,
   output logic                   full,
   output logic                   pop_valid,
   output ilt_pkg::ilt_class_type pop_item,
   input  logic                   pop
);
   import ilt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ilt_class_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = store_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/ilt_back.sv
// ----------------------------------------------------------------------------
// ilt_back
// Runs the line parser state machine on classified bytes and holds the
// response word in an output register.
// ----------------------------------------------------------------------------
module ilt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  ilt_pkg::ilt_class_type   item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ilt_pkg::rsp_payload_type rsp_payload
);
   import ilt_pkg::*;

   // Parser states.
   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_SSTART  = 3'd1;
   localparam logic [2:0] ST_SECTION = 3'd2;
   localparam logic [2:0] ST_NAME    = 3'd3;
   localparam logic [2:0] ST_PRE_EQ  = 3'd4;
   localparam logic [2:0] ST_POST_EQ = 3'd5;
   localparam logic [2:0] ST_VALUE   = 3'd6;
   localparam logic [2:0] ST_END     = 3'd7;

   // Bits of the found flags.
   localparam int FOUND_SECTION = 0;
   localparam int FOUND_NAME    = 1;
   localparam int FOUND_VALUE   = 2;

   logic [2:0]      state_ff, state_in;
   logic            stopped_ff, stopped_in;
   logic            failed_ff, failed_in;
   logic [2:0]      found_ff, found_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [2:0]      role;
   logic [2:0]      start;
   logic [3:0]      err;
   logic [2:0]      st_next;
   logic            stop_next;
   logic            fail_next;
   logic [2:0]      found_next;

   // A byte is processed whenever the output register is free or draining.
   assign pop         = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // State transition and per-byte classification.
   always_comb begin
      role       = ROLE_IGNORED;
      start      = START_NONE;
      err        = ERR_NONE;
      st_next    = state_ff;
      stop_next  = stopped_ff;
      fail_next  = failed_ff;
      found_next = found_ff;
      if (!stopped_ff) begin
         case (state_ff)
            ST_INIT: begin
               if (item.is_nl) begin
                  role      = ROLE_DELIM;
                  stop_next = 1'b1;
               end else if (item.is_space) begin
                  role = ROLE_IGNORED;
               end else if (item.is_lbr) begin
                  role    = ROLE_DELIM;
                  st_next = ST_SSTART;
               end else if (item.is_ident) begin
                  role                   = ROLE_NAME;
                  start                  = START_NAME;
                  found_next[FOUND_NAME] = 1'b1;
                  st_next                = ST_NAME;
               end else begin
                  err = ERR_LINE_START;
               end
            end
            ST_SSTART: begin
               if (item.is_ident) begin
                  role                      = ROLE_SECTION;
                  start                     = START_SECT;
                  found_next[FOUND_SECTION] = 1'b1;
                  st_next                   = ST_SECTION;
               end else begin
                  err = ERR_SECT_START;
               end
            end
            ST_SECTION: begin
               if (item.is_rbr) begin
                  role    = ROLE_DELIM;
                  st_next = ST_END;
               end else if (item.is_ident) begin
                  role = ROLE_SECTION;
               end else begin
                  err = ERR_SECTION;
               end
            end
            ST_NAME: begin
               if (item.is_nl) begin
                  err = ERR_NAME_EOL;
               end else if (item.is_space) begin
                  role    = ROLE_DELIM;
                  st_next = ST_PRE_EQ;
               end else if (item.is_eq) begin
                  role    = ROLE_DELIM;
                  st_next = ST_POST_EQ;
               end else if (item.is_ident) begin
                  role = ROLE_NAME;
               end else begin
                  err = ERR_NAME;
               end
            end
            ST_PRE_EQ: begin
               if (item.is_nl) begin
                  err = ERR_PRE_EQ_EOL;
               end else if (item.is_space) begin
                  role = ROLE_IGNORED;
               end else if (item.is_eq) begin
                  role    = ROLE_DELIM;
                  st_next = ST_POST_EQ;
               end else begin
                  err = ERR_PRE_EQ;
               end
            end
            ST_POST_EQ: begin
               if (item.is_nl) begin
                  role                    = ROLE_DELIM;
                  start                   = START_EMPTY;
                  found_next[FOUND_VALUE] = 1'b1;
                  st_next                 = ST_END;
               end else if (item.is_space) begin
                  role = ROLE_IGNORED;
               end else if (item.is_print) begin
                  role                    = ROLE_VALUE;
                  start                   = START_VALUE;
                  found_next[FOUND_VALUE] = 1'b1;
                  st_next                 = ST_VALUE;
               end else begin
                  err = ERR_POST_EQ;
               end
            end
            ST_VALUE: begin
               if (item.is_nl) begin
                  role    = ROLE_DELIM;
                  st_next = ST_END;
               end else if (item.is_print) begin
                  role = ROLE_VALUE;
               end else begin
                  err = ERR_VALUE;
               end
            end
            default: begin
               // End of line: only white space may follow.
               if (!item.is_space) begin
                  err = ERR_END;
               end
            end
         endcase
         // The illegal byte itself carries no role and stops the line.
         if (err != ERR_NONE) begin
            role      = ROLE_IGNORED;
            start     = START_NONE;
            stop_next = 1'b1;
            fail_next = 1'b1;
         end
      end
   end

   // Response word and next parser state.
   always_comb begin
      rsp_payload_in             = '0;
      rsp_payload_in.byte_role   = role;
      rsp_payload_in.token_start = start;
      rsp_payload_in.error_code  = err;
      rsp_payload_in.line_done   = item.last;
      rsp_payload_in.line_ok     = item.last && !fail_next;
      rsp_payload_in.saw_section = item.last && found_next[FOUND_SECTION];
      rsp_payload_in.saw_name    = item.last && found_next[FOUND_NAME];
      rsp_payload_in.saw_value   = item.last && found_next[FOUND_VALUE];

      state_in   = state_ff;
      stopped_in = stopped_ff;
      failed_in  = failed_ff;
      found_in   = found_ff;
      if (pop) begin
         if (item.last) begin
            state_in   = ST_INIT;
            stopped_in = 1'b0;
            failed_in  = 1'b0;
            found_in   = '0;
         end else begin
            state_in   = st_next;
            stopped_in = stop_next;
            failed_in  = fail_next;
            found_in   = found_next;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         stopped_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         found_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stopped_ff   <= stopped_in;
         failed_ff    <= failed_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// File: rtl/ini_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// ini_line_tokenizer_unit
// Configuration line tokenizer: classifies the bytes of a section header or
// name = value line, one byte per word, and reports roles, token starts,
// errors and a line summary.
//
//   Channel  Direction  Handshake              Word
//   req_     in         req_valid / req_ready  byte_in, last_of_line
//   rsp_     out        rsp_valid / rsp_ready  role, start, error, summary
//
// One word per cycle is sustained while responses are taken; a byte taken is
// first written into the queue, then the parser writes its response to the output register.
// The parser state machine handles one byte per cycle unless stalled, and sets the rate.
// Reset is synchronous and empties the queue and the output register.
// A stalled response holds the parser; requests keep flowing until the queue
// of QUEUE_DEPTH words is full.
// ----------------------------------------------------------------------------
module ini_line_tokenizer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ilt_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ilt_pkg::rsp_payload_type rsp_payload
);
   import ilt_pkg::*;

   logic          queue_full;
   logic          push;
   ilt_class_type push_item;
   logic          pop_valid;
   ilt_class_type pop_item;
   logic          pop;

   // Front: take request words and decode character classes.
   ilt_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   // Queue between front and back.
   ilt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop)
   );

   // Back: parser state machine and response register.
   ilt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (pop_valid),
      .item        (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/ilt_checker.sv
// ----------------------------------------------------------------------------
// ilt_checker
// Port-level checks on the line tokenizer response channel.
// ----------------------------------------------------------------------------
`include "ini_line_tokenizer_unit_macros.svh"

module ilt_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ilt_pkg::rsp_payload_type rsp_payload
);
   import ilt_pkg::*;

   logic summary_clear;
   logic error_clean;
   logic start_has_role;

   // Summary bits are only meaningful on the last byte of a line.
   assign summary_clear = !rsp_payload.line_ok && !rsp_payload.saw_section
                          && !rsp_payload.saw_name && !rsp_payload.saw_value;
   // The illegal byte carries no role and starts no token.
   assign error_clean   = (rsp_payload.byte_role == ROLE_IGNORED)
                          && (rsp_payload.token_start == START_NONE);
   // A token start always comes with a role.
   assign start_has_role = (rsp_payload.byte_role != ROLE_IGNORED);

   // A stalled response stays put.
   `ILT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   `ILT_ASSERT_NOW(a_summary_zero, rsp_valid && !rsp_payload.line_done, summary_clear, "summary bits set mid-line")

   `ILT_ASSERT_NOW(a_error_clean, rsp_valid && (rsp_payload.error_code != ERR_NONE), error_clean, "error byte has role or start")

   `ILT_ASSERT_NOW(a_start_role, rsp_valid && (rsp_payload.token_start != START_NONE), start_has_role && (rsp_payload.error_code == ERR_NONE), "token start without role")

   `ILT_ASSERT_NOW(a_error_range, rsp_valid, rsp_payload.error_code <= ERR_END, "error code out of range")

endmodule

bind ini_line_tokenizer_unit ilt_checker u_ilt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the configuration line tokenizer. Lines are fed one
// byte word at a time. A directed set reaches every error code, token start
// and byte role. Random lines follow: mostly well-formed section headers and
// name = value pairs, plus broken lines and noise. Both channels idle and
// stall at random. A scoreboard predicts each result word in order of
// acceptance and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ilt_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 1000000;

   // Parser position within a line.
   typedef enum logic [2:0] {
      AT_LINE_START,
      IN_SECT_OPEN,
      IN_SECTION,
      IN_NAME,
      BEFORE_EQ,
      AFTER_EQ,
      IN_VALUE,
      AT_LINE_END
   } line_pos_type;

   // Predicts the tokenizer's result words and checks them in order.
   class line_checker;
      rsp_payload_type result_words[$];
      line_pos_type    position;
      bit              stopped;
      bit              failed;
      bit              seen_section;
      bit              seen_name;
      bit              seen_value;
      int              fails;

      function new();
         fails = 0;
         restart_line();
      endfunction

      function void restart_line();
         position     = AT_LINE_START;
         stopped      = 1'b0;
         failed       = 1'b0;
         seen_section = 1'b0;
         seen_name    = 1'b0;
         seen_value   = 1'b0;
      endfunction

      function bit is_blank(logic [7:0] c);
         return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
      endfunction

      function bit is_printable(logic [7:0] c);
         return c >= 8'h20 && c <= 8'h7E;
      endfunction

      function bit is_word_char(logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                (c >= "a" && c <= "z") || c == CHAR_UND || c == CHAR_DSH;
      endfunction

      // Notes an accepted byte word and queues the result it must produce.
      function void note_byte(req_payload_type word);
         rsp_payload_type res;
         logic [7:0]      c;
         logic [3:0]      err;
         c   = word.byte_in;
         err = ERR_NONE;
         res = '0;
         if (!stopped) begin
            case (position)
               AT_LINE_START: begin
                  if (c == CHAR_NL) begin
                     res.byte_role = ROLE_DELIM;
                     stopped = 1'b1;
                  end else if (c == CHAR_LBR) begin
                     res.byte_role = ROLE_DELIM;
                     position = IN_SECT_OPEN;
                  end else if (is_word_char(c)) begin
                     res.byte_role   = ROLE_NAME;
                     res.token_start = START_NAME;
                     seen_name = 1'b1;
                     position = IN_NAME;
                  end else if (!is_blank(c)) begin
                     err = ERR_LINE_START;
                  end
               end
               IN_SECT_OPEN: begin
                  if (is_word_char(c)) begin
                     res.byte_role   = ROLE_SECTION;
                     res.token_start = START_SECT;
                     seen_section = 1'b1;
                     position = IN_SECTION;
                  end else begin
                     err = ERR_SECT_START;
                  end
               end
               IN_SECTION: begin
                  if (c == CHAR_RBR) begin
                     res.byte_role = ROLE_DELIM;
                     position = AT_LINE_END;
                  end else if (is_word_char(c)) begin
                     res.byte_role = ROLE_SECTION;
                  end else begin
                     err = ERR_SECTION;
                  end
               end
               IN_NAME: begin
                  if (c == CHAR_NL) begin
                     err = ERR_NAME_EOL;
                  end else if (is_blank(c)) begin
                     res.byte_role = ROLE_DELIM;
                     position = BEFORE_EQ;
                  end else if (c == CHAR_EQ) begin
                     res.byte_role = ROLE_DELIM;
                     position = AFTER_EQ;
                  end else if (is_word_char(c)) begin
                     res.byte_role = ROLE_NAME;
                  end else begin
                     err = ERR_NAME;
                  end
               end
               BEFORE_EQ: begin
                  if (c == CHAR_NL) begin
                     err = ERR_PRE_EQ_EOL;
                  end else if (c == CHAR_EQ) begin
                     res.byte_role = ROLE_DELIM;
                     position = AFTER_EQ;
                  end else if (!is_blank(c)) begin
                     err = ERR_PRE_EQ;
                  end
               end
               AFTER_EQ: begin
                  // A newline right after the equals sign marks an empty value.
                  if (c == CHAR_NL) begin
                     res.byte_role   = ROLE_DELIM;
                     res.token_start = START_EMPTY;
                     seen_value = 1'b1;
                     position = AT_LINE_END;
                  end else if (!is_blank(c)) begin
                     if (is_printable(c)) begin
                        res.byte_role   = ROLE_VALUE;
                        res.token_start = START_VALUE;
                        seen_value = 1'b1;
                        position = IN_VALUE;
                     end else begin
                        err = ERR_POST_EQ;
                     end
                  end
               end
               IN_VALUE: begin
                  if (c == CHAR_NL) begin
                     res.byte_role = ROLE_DELIM;
                     position = AT_LINE_END;
                  end else if (is_printable(c)) begin
                     res.byte_role = ROLE_VALUE;
                  end else begin
                     err = ERR_VALUE;
                  end
               end
               default: begin
                  if (!is_blank(c)) err = ERR_END;
               end
            endcase
            // The illegal byte itself carries no role and stops the line.
            if (err != ERR_NONE) begin
               res.byte_role   = ROLE_IGNORED;
               res.token_start = START_NONE;
               stopped = 1'b1;
               failed  = 1'b1;
            end
         end
         res.error_code  = err;
         res.line_done   = word.last_of_line;
         res.line_ok     = word.last_of_line && !failed;
         res.saw_section = word.last_of_line && seen_section;
         res.saw_name    = word.last_of_line && seen_name;
         res.saw_value   = word.last_of_line && seen_value;
         result_words.push_back(res);
         if (word.last_of_line) restart_line();
      endfunction

      function void compare_field(string field, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fails++;
         end
      endfunction

      // Checks one result word against the oldest prediction.
      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (result_words.size() == 0) begin
            $error("result word with none expected: %h", got);
            fails++;
         end else begin
            want = result_words.pop_front();
            compare_field("byte_role", 4'(want.byte_role), 4'(got.byte_role));
            compare_field("token_start", 4'(want.token_start), 4'(got.token_start));
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("line_done", 4'(want.line_done), 4'(got.line_done));
            compare_field("line_ok", 4'(want.line_ok), 4'(got.line_ok));
            compare_field("saw_section", 4'(want.saw_section), 4'(got.saw_section));
            compare_field("saw_name", 4'(want.saw_name), 4'(got.saw_name));
            compare_field("saw_value", 4'(want.saw_value), 4'(got.saw_value));
         end
      endfunction

      function int pending();
         return result_words.size();
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   line_checker board;
   logic [7:0]  line_buf[$];
   bit          calm = 1'b0;
   int          sent_count = 0;
   int          ready_left = 0;
   int          cycle_count = 0;

   ini_line_tokenizer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one byte word and waits until it is taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{byte_in: b, last_of_line: last};
      do @(posedge clock); while (!req_ready);
      board.note_byte(req_payload);
      sent_count++;
   endtask

   // Sends the buffered line, marking its final byte.
   task automatic send_line();
      calm <= ($urandom_range(0, 9) == 0);
      foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 7))
         0: return 8'h09;
         1: return 8'h0B;
         2: return 8'h0C;
         3: return 8'h0D;
         default: return 8'h20;
      endcase
   endfunction

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 63);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("A" + r - 10);
      if (r < 62) return 8'("a" + r - 36);
      return (r == 62) ? CHAR_UND : CHAR_DSH;
   endfunction

   // A byte likely to break a line: any byte, or one near a class edge.
   function automatic logic [7:0] odd_char();
      case ($urandom_range(0, 19))
         0: return CHAR_NL;
         1: return CHAR_LBR;
         2: return CHAR_RBR;
         3: return CHAR_EQ;
         4: return 8'h20;
         5: return 8'h00;
         6: return 8'h7F;
         7: return 8'h80;
         8: return 8'hFF;
         9: return 8'h1F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_blanks(input int n);
      repeat (n) line_buf.push_back(blank_char());
   endtask

   task automatic add_ident(input int n);
      repeat (n) line_buf.push_back(word_char());
   endtask

   // Optional newline, sometimes with trailing blanks.
   task automatic add_ending();
      if ($urandom_range(0, 9) < 7) begin
         line_buf.push_back(CHAR_NL);
         if ($urandom_range(0, 4) == 0) add_blanks($urandom_range(1, 2));
      end
   endtask

   task automatic add_pair();
      add_blanks($urandom_range(0, 2));
      add_ident($urandom_range(1, 6));
      add_blanks($urandom_range(0, 2));
      line_buf.push_back(CHAR_EQ);
      add_blanks($urandom_range(0, 2));
      repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      add_ending();
   endtask

   task automatic add_section();
      add_blanks($urandom_range(0, 2));
      line_buf.push_back(CHAR_LBR);
      add_ident($urandom_range(1, 6));
      if ($urandom_range(0, 9) != 0) line_buf.push_back(CHAR_RBR);
      add_ending();
   endtask

   // One random line: well-formed most of the time, otherwise broken or noise.
   task automatic build_random_line();
      int kind;
      int spot;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         add_pair();
      end else if (kind < 55) begin
         add_section();
      end else if (kind < 63) begin
         if ($urandom_range(0, 1) == 1) begin
            line_buf.push_back(CHAR_NL);
            repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            add_blanks($urandom_range(1, 3));
         end
      end else if (kind < 85) begin
         if (kind % 2 == 1) add_pair();
         else add_section();
         spot = $urandom_range(0, line_buf.size() - 1);
         line_buf[spot] = odd_char();
         if ($urandom_range(0, 3) == 0) begin
            while (line_buf.size() > 1 && $urandom_range(0, 1) == 1) void'(line_buf.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 8)) line_buf.push_back(odd_char());
      end
   endtask

   // Result side: check every accepted word, stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_payload);
      if (ready_left > 0) begin
         ready_left--;
      end else if (rsp_ready && !calm) begin
         ready_left = pick_gap();
         if (ready_left > 0) rsp_ready <= 1'b0;
         else ready_left = $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
         ready_left = $urandom_range(0, 15);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int target;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed lines: every error code, the newline at line start, the empty
      // value, and the bytes at the ends of the range.
      line_buf = '{8'h00};                   send_line();
      line_buf = '{CHAR_NL, 8'hFF};          send_line();
      line_buf = '{CHAR_LBR, CHAR_RBR};      send_line();
      line_buf = '{CHAR_LBR, "a", "."};      send_line();
      line_buf = '{"a", CHAR_NL};            send_line();
      line_buf = '{"a", "."};                send_line();
      line_buf = '{"a", 8'h20, CHAR_NL};     send_line();
      line_buf = '{"a", 8'h20, "x"};         send_line();
      line_buf = '{"a", CHAR_EQ, 8'h7F};     send_line();
      line_buf = '{"a", CHAR_EQ, "v", 8'h80}; send_line();
      line_buf = '{"a", CHAR_EQ, CHAR_NL, 8'hFF}; send_line();

      // Random lines.
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) begin
         build_random_line();
         send_line();
      end
      req_valid <= 1'b0;
      calm <= 1'b0;

      // Wait for every predicted word, then a little longer for strays.
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fails == 0 && board.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/ilt_pkg.sv
rtl/ilt_front.sv
rtl/ilt_queue.sv
rtl/ilt_back.sv
rtl/ini_line_tokenizer_unit.sv
rtl/ilt_checker.sv
tb/tb_top.sv
